@@ rtl/core/tncs_pkg.sv @@
// Shared types, constants and the weight table of the Tokhura nearest-codeword search.
package tncs_pkg;

    // Default configuration
    localparam int P_CODEWORDS = 8;
    localparam int P_DIM       = 12;
    localparam int P_ELEM_BITS = 16;

    // Fixed field widths
    localparam int CWIDX_W  = 3;
    localparam int EIDX_W   = 4;
    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 6;
    localparam int DIST_W   = 48;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    // Control that travels with one codeword step down the pipeline
    typedef struct packed {
        logic vld;      // step carries work
        logic restart;  // element 0: accumulator starts from zero
        logic last;     // final element: track the minimum
        logic tail;     // final codeword of this element
    } t_step_ctl;

    // Status from the accumulator back to the sequencer
    typedef struct packed {
        logic done;     // tail step written back
        logic hit;      // a search result is ready
    } t_acc_stat;

    // Tokhura weight by element position; positions past the list weigh zero
    function automatic logic [WEIGHT_W-1:0] tncs_weight(input logic [EIDX_W-1:0] e);
        logic [WEIGHT_W-1:0] w;
        unique case (e)
            4'd0:    w = 6'd1;
            4'd1:    w = 6'd3;
            4'd2:    w = 6'd7;
            4'd3:    w = 6'd13;
            4'd4:    w = 6'd19;
            4'd5:    w = 6'd22;
            4'd6:    w = 6'd25;
            4'd7:    w = 6'd33;
            4'd8:    w = 6'd42;
            4'd9:    w = 6'd50;
            4'd10:   w = 6'd56;
            4'd11:   w = 6'd61;
            default: w = 6'd0;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/tncs_codebook.sv @@
// Codebook memory: one write port, one registered read port.
module tncs_codebook
    import tncs_pkg::*;
#(
    parameter int DEPTH = P_CODEWORDS * P_DIM,
    parameter int AW    = $clog2(P_CODEWORDS * P_DIM),
    parameter int W     = P_ELEM_BITS
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tncs_term.sv @@
// Weighted squared difference: subtract and square, then scale by the weight.
module tncs_term
    import tncs_pkg::*;
#(
    parameter int ELEM_BITS = P_ELEM_BITS,
    parameter int IW        = $clog2(P_CODEWORDS),
    parameter int TERM_W    = 2 * (P_ELEM_BITS + 1) + WEIGHT_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_step_ctl                  i_ctl,
    input  logic [IW-1:0]              i_idx,
    input  logic signed [ELEM_BITS-1:0] i_cb,
    input  logic signed [ELEM_BITS-1:0] i_q,
    input  logic [WEIGHT_W-1:0]        i_w,
    output t_step_ctl                  o_sq_ctl,
    output logic [IW-1:0]              o_sq_idx,
    output logic [TERM_W-1:0]          o_term
);

    localparam int DW   = ELEM_BITS + 1;
    localparam int SQ_W = 2 * DW;

    logic signed [DW-1:0] diff;
    logic [DW-1:0]        absd;
    logic [SQ_W-1:0]      r_sq;
    t_step_ctl            r_ctl;
    logic [IW-1:0]        r_idx;
    logic [TERM_W-1:0]    r_term;

    // Exact difference and its magnitude
    assign diff = DW'(i_cb) - DW'(i_q);
    assign absd = diff[DW-1] ? DW'(-diff) : DW'(diff);

    // Stage 1: square
    always_ff @(posedge i_clk) begin
        r_sq  <= SQ_W'(absd) * SQ_W'(absd);
        r_idx <= i_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Stage 2: weight
    always_ff @(posedge i_clk) begin
        r_term <= TERM_W'(r_sq) * TERM_W'(i_w);
    end

    assign o_sq_ctl = r_ctl;
    assign o_sq_idx = r_idx;
    assign o_term   = r_term;

endmodule

@@ rtl/core/tncs_accum.sv @@
// Distance accumulator memory with saturating read-modify-write and running minimum.
module tncs_accum
    import tncs_pkg::*;
#(
    parameter int CODEWORDS = P_CODEWORDS,
    parameter int IW        = $clog2(P_CODEWORDS),
    parameter int TERM_W    = 2 * (P_ELEM_BITS + 1) + WEIGHT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_step_ctl         i_ctl,
    input  logic [IW-1:0]     i_idx,
    input  logic [TERM_W-1:0] i_term,
    output t_acc_stat         o_stat,
    output logic [IW-1:0]     o_best_idx,
    output logic [DIST_W-1:0] o_best_dist
);

    localparam int SUM_W = ((TERM_W > DIST_W) ? TERM_W : DIST_W) + 1;

    logic [DIST_W-1:0]    r_mem [CODEWORDS];
    logic [CODEWORDS-1:0] r_vld;
    logic [DIST_W-1:0]    r_rd;
    logic                 r_rd_vld;
    t_step_ctl            r_ctl;
    logic [IW-1:0]        r_idx;
    logic [DIST_W-1:0]    r_best_dist;
    logic [IW-1:0]        r_best_idx;

    logic [DIST_W-1:0] acc;
    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] sat;
    logic              take;

    // Read stage: data registered, entry not valid reads as zero
    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[i_idx];
        r_rd_vld <= r_vld[i_idx] & ~i_ctl.restart;
        r_idx    <= i_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Saturating add
    assign acc = r_rd_vld ? r_rd : '0;
    assign sum = SUM_W'(acc) + SUM_W'(i_term);
    assign sat = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

    // Write back
    always_ff @(posedge i_clk) begin
        if (r_ctl.vld) begin
            r_mem[r_idx] <= sat;
        end
    end

    // Valid bits; a finished search clears them all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_ctl.vld && r_ctl.last && r_ctl.tail) begin
            r_vld <= '0;
        end else if (r_ctl.vld) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    // Running minimum, strict less-than keeps the lower index on ties
    assign take = (r_idx == '0) || (sat < r_best_dist);

    always_ff @(posedge i_clk) begin
        if (r_ctl.vld && r_ctl.last && take) begin
            r_best_dist <= sat;
            r_best_idx  <= r_idx;
        end
    end

    assign o_best_dist = take ? sat : r_best_dist;
    assign o_best_idx  = take ? r_idx : r_best_idx;
    assign o_stat.done = r_ctl.vld & r_ctl.tail;
    assign o_stat.hit  = r_ctl.vld & r_ctl.tail & r_ctl.last;

endmodule

@@ rtl/core/tokhura_nearest_codeword_search_top.sv @@
// Top level of the Tokhura nearest-codeword search: sequencer, output register, hookup.
//
//   channel  direction  handshake         payload
//   input    in         i_valid/o_ready   i_opcode, i_codeword_index, i_element_index,
//                                         i_element_value
//   output   out        o_valid/i_ready   o_best_index, o_best_distance
//
// A load transaction is one codebook write. A query element makes one codebook read
// per codeword, then the square, weight and accumulator write-back stages drain before
// the next transaction.
// Synchronous active-low reset clears the accumulator valid bits and the control.
// A result waits in the output register; only another final query element stalls on it.
module tokhura_nearest_codeword_search_top
    import tncs_pkg::*;
#(
    parameter int CODEWORDS = P_CODEWORDS,
    parameter int DIM       = P_DIM,
    parameter int ELEM_BITS = P_ELEM_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_opcode,
    input  logic [CWIDX_W-1:0]        i_codeword_index,
    input  logic [EIDX_W-1:0]         i_element_index,
    input  logic signed [VALUE_W-1:0] i_element_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [CWIDX_W-1:0]        o_best_index,
    output logic [DIST_W-1:0]         o_best_distance
);

    localparam int DEPTH  = CODEWORDS * DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW     = $clog2(CODEWORDS);
    localparam int TERM_W = 2 * (ELEM_BITS + 1) + WEIGHT_W;

    t_state                      r_state, n_state;
    logic [IW-1:0]               r_cnt;
    logic [AW-1:0]               r_addr;
    logic [EIDX_W-1:0]           r_e;
    logic signed [ELEM_BITS-1:0] r_q;
    logic [WEIGHT_W-1:0]         r_w;
    t_step_ctl                   r_ctl0;
    logic [IW-1:0]               r_idx0;
    logic                        r_out_valid;
    logic [IW-1:0]               r_out_idx;
    logic [DIST_W-1:0]           r_out_dist;

    logic                        accept;
    logic                        in_range;
    logic                        final_query;
    logic                        cb_we;
    logic [AW-1:0]               cb_waddr;
    logic signed [ELEM_BITS-1:0] elem;
    logic signed [ELEM_BITS-1:0] cb_rdata;
    t_step_ctl                   issue_ctl;
    t_step_ctl                   sq_ctl;
    logic [IW-1:0]               sq_idx;
    logic [TERM_W-1:0]           term;
    t_acc_stat                   stat;
    logic [IW-1:0]               best_idx;
    logic [DIST_W-1:0]           best_dist;

    // Input decode
    assign elem        = ELEM_BITS'(i_element_value);
    assign in_range    = 32'(i_element_index) < DIM;
    assign final_query = (i_opcode == OP_QUERY) && (32'(i_element_index) == DIM - 1);
    assign o_ready     = (r_state == S_IDLE) && (!r_out_valid || i_ready || !final_query);
    assign accept      = i_valid && o_ready;

    // Codebook load
    assign cb_we    = accept && in_range && (i_opcode == OP_LOAD)
                      && (32'(i_codeword_index) < CODEWORDS);
    assign cb_waddr = AW'(32'(i_codeword_index) * DIM + 32'(i_element_index));

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_range && (i_opcode == OP_QUERY)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == IW'(CODEWORDS - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (stat.done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Query element capture and codeword walk
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_cnt  <= '0;
            r_addr <= AW'(i_element_index);
            r_e    <= i_element_index;
            r_q    <= elem;
            r_w    <= tncs_weight(i_element_index);
        end else if (r_state == S_RUN) begin
            r_cnt  <= r_cnt + IW'(1);
            r_addr <= r_addr + AW'(DIM);
        end
    end

    // Step control, aligned with the codebook read data
    assign issue_ctl.vld     = (r_state == S_RUN);
    assign issue_ctl.restart = (r_e == '0);
    assign issue_ctl.last    = (32'(r_e) == DIM - 1);
    assign issue_ctl.tail    = (r_cnt == IW'(CODEWORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0 <= issue_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx0 <= r_cnt;
    end

    tncs_codebook #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (ELEM_BITS)
    ) u_codebook (
        .i_clk   (i_clk),
        .i_we    (cb_we),
        .i_waddr (cb_waddr),
        .i_wdata (elem),
        .i_raddr (r_addr),
        .o_rdata (cb_rdata)
    );

    tncs_term #(
        .ELEM_BITS (ELEM_BITS),
        .IW        (IW),
        .TERM_W    (TERM_W)
    ) u_term (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl0),
        .i_idx    (r_idx0),
        .i_cb     (cb_rdata),
        .i_q      (r_q),
        .i_w      (r_w),
        .o_sq_ctl (sq_ctl),
        .o_sq_idx (sq_idx),
        .o_term   (term)
    );

    tncs_accum #(
        .CODEWORDS (CODEWORDS),
        .IW        (IW),
        .TERM_W    (TERM_W)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (sq_ctl),
        .i_idx       (sq_idx),
        .i_term      (term),
        .o_stat      (stat),
        .o_best_idx  (best_idx),
        .o_best_dist (best_dist)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.hit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.hit) begin
            r_out_idx  <= best_idx;
            r_out_dist <= best_dist;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_best_index    = CWIDX_W'(r_out_idx);
    assign o_best_distance = r_out_dist;

endmodule

@@ test/tokhura_nearest_codeword_search_top_test.sv @@
// Self-checking testbench for the Tokhura nearest-codeword search top level.
module tokhura_nearest_codeword_search_top_test;
    import tncs_pkg::*;

    localparam int CODEWORDS     = P_CODEWORDS;
    localparam int DIM           = P_DIM;
    localparam int QUERY_CYCLES  = CODEWORDS + 4;
    localparam int SETTLE_CYCLES = 4 * QUERY_CYCLES;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 400;
    // Enough maximal terms at position 10 (weight 56) to pin every accumulator at the cap
    localparam int SAT_STEPS     = 1175;
    localparam longint unsigned DIST_CAP = DIST_MAX;
    localparam longint unsigned TOKHURA_W [12] = '{1, 3, 7, 13, 19, 22, 25, 33, 42, 50, 56, 61};

    typedef struct {
        logic                      op;
        logic [CWIDX_W-1:0]        cw;
        logic [EIDX_W-1:0]         elem;
        logic signed [VALUE_W-1:0] value;
        bit                        drain;   // hold this one back until no result is pending
    } t_search_item;

    typedef struct {
        logic [CWIDX_W-1:0] idx;
        logic [DIST_W-1:0]  distance;
    } t_nearest;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic                      i_opcode = OP_LOAD;
    logic [CWIDX_W-1:0]        i_codeword_index = '0;
    logic [EIDX_W-1:0]         i_element_index = '0;
    logic signed [VALUE_W-1:0] i_element_value = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [CWIDX_W-1:0]        o_best_index;
    logic [DIST_W-1:0]         o_best_distance;

    t_search_item pending_items[$];
    t_nearest     nearest_q[$];
    t_search_item active_item;

    // Predictor state, and the codebook as seen while building stimulus
    logic signed [VALUE_W-1:0] cb_copy [CODEWORDS][DIM];
    logic [DIST_W-1:0]         dist_acc [CODEWORDS];
    logic signed [VALUE_W-1:0] shadow_cb [CODEWORDS][DIM];

    int n_total = 0, n_accepted = 0, n_effective = 0;
    int n_loads = 0, n_queries = 0, n_ignored = 0;
    int n_results = 0, n_saturated = 0, errors = 0;
    int gap_left = 0, burst_left = 0;
    int stall_mode = 0, stall_left = 0;
    int cycle_cnt = 0;

    tokhura_nearest_codeword_search_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_codeword_index (i_codeword_index),
        .i_element_index  (i_element_index),
        .i_element_value  (i_element_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_best_index     (o_best_index),
        .o_best_distance  (o_best_distance)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Apply one accepted transaction; the last query element yields the nearest codeword
    function automatic void tokhura_predict(input t_search_item it);
        longint signed   diff;
        longint unsigned term, acc, bd;
        int              best;
        t_nearest        res;
        if (it.elem >= DIM) return;
        if (it.op == OP_LOAD) begin
            cb_copy[it.cw][it.elem] = it.value;
            return;
        end
        for (int i = 0; i < CODEWORDS; i++) begin
            diff = longint'(cb_copy[i][it.elem]) - longint'(it.value);
            if (diff < 0) diff = -diff;
            term = longint'(diff) * longint'(diff) * TOKHURA_W[it.elem];
            acc  = (it.elem == 0) ? 64'd0 : 64'(dist_acc[i]);
            if (term > DIST_CAP - acc) acc = DIST_CAP;
            else acc = acc + term;
            dist_acc[i] = acc[DIST_W-1:0];
        end
        if (it.elem != DIM - 1) return;
        best = 0;
        bd   = dist_acc[0];
        for (int i = 1; i < CODEWORDS; i++) begin
            if (dist_acc[i] < bd) begin
                bd   = dist_acc[i];
                best = i;
            end
        end
        res.idx      = best[CWIDX_W-1:0];
        res.distance = bd[DIST_W-1:0];
        nearest_q    = {nearest_q, res};
        for (int i = 0; i < CODEWORDS; i++) dist_acc[i] = '0;
    endfunction

    function automatic void add_item(input logic op, input int cw, input int elem,
                                     input logic signed [VALUE_W-1:0] value,
                                     input bit drain = 1'b0);
        t_search_item it;
        it.op    = op;
        it.cw    = cw[CWIDX_W-1:0];
        it.elem  = elem[EIDX_W-1:0];
        it.value = value;
        it.drain = drain;
        pending_items = {pending_items, it};
        n_total++;
        if (elem < DIM) begin
            n_effective++;
            if (op == OP_LOAD) shadow_cb[cw][elem] = value;
        end
    endfunction

    // Element values weighted toward the extremes and small magnitudes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int t;
        case ($urandom_range(0, 7))
            0: t = 32767;
            1: t = -32768;
            2: t = int'($urandom_range(0, 255)) - 128;
            default: t = int'($urandom);
        endcase
        return t[VALUE_W-1:0];
    endfunction

    // Stimulus, reset and end of run
    initial begin : stimulus
        int k, n, src, dst, mode, base_items, waited;
        logic signed [VALUE_W-1:0] v;

        // Full codebook first: codeword 0 at the top, 7 at the bottom, 6 a copy of 2
        for (int c = 0; c < CODEWORDS; c++) begin
            for (int e = 0; e < DIM; e++) begin
                if (c == 0) v = 16'sh7fff;
                else if (c == CODEWORDS - 1) v = 16'sh8000;
                else if (c == 6) v = shadow_cb[2][e];
                else v = pick_value();
                add_item(OP_LOAD, c, e, v);
            end
        end

        // Query equal to codeword 2: zero distance, tie with 6 goes to the lower index.
        // Ignored positions are slipped into the middle of the vector.
        for (int e = 0; e < DIM; e++) begin
            add_item(OP_QUERY, $urandom_range(0, 7), e, shadow_cb[2][e]);
            if (e == 5) begin
                add_item(OP_LOAD, 3, 15, 16'sh7fff);
                add_item(OP_QUERY, 5, 12, 16'sh8000);
            end
        end
        // Alternating extreme query values
        for (int e = 0; e < DIM; e++)
            add_item(OP_QUERY, 7 - (e % 8), e, (e % 2) ? 16'sh8000 : 16'sh7fff);

        // Saturation: all codewords at the bottom of position 10, query at the top
        for (int c = 0; c < CODEWORDS; c++) add_item(OP_LOAD, c, 10, 16'sh8000, c == 0);
        add_item(OP_QUERY, 0, 0, 16'sh0000);
        for (int j = 0; j < SAT_STEPS; j++) add_item(OP_QUERY, j % 8, 10, 16'sh7fff);
        add_item(OP_QUERY, 1, DIM - 1, 16'sh7fff);
        for (int c = 0; c < CODEWORDS; c++) add_item(OP_LOAD, c, 10, pick_value(), c == 0);

        // Random part: mostly whole vectors, some codebook churn, broken vectors and noise
        base_items = n_effective;
        while (n_effective < base_items + RANDOM_ITEMS) begin
            k = $urandom_range(0, 99);
            if (k < 60) begin
                src  = $urandom_range(0, CODEWORDS - 1);
                mode = $urandom_range(0, 3);
                for (int e = 0; e < DIM; e++) begin
                    case (mode)
                        0: v = shadow_cb[src][e];
                        1: v = shadow_cb[src][e] + VALUE_W'(int'($urandom_range(0, 127)) - 64);
                        2: v = VALUE_W'($urandom);
                        default: v = pick_value();
                    endcase
                    add_item(OP_QUERY, $urandom_range(0, 7), e, v);
                end
            end else if (k < 75) begin
                add_item(OP_LOAD, $urandom_range(0, 7), $urandom_range(0, DIM - 1),
                         pick_value());
            end else if (k < 80) begin
                src = $urandom_range(0, CODEWORDS - 1);
                dst = (src + $urandom_range(1, CODEWORDS - 1)) % CODEWORDS;
                for (int e = 0; e < DIM; e++) add_item(OP_LOAD, dst, e, shadow_cb[src][e]);
            end else if (k < 90) begin
                n = $urandom_range(1, DIM - 1);
                for (int j = 0; j < n; j++)
                    add_item(OP_QUERY, $urandom_range(0, 7),
                             $urandom_range(0, 1) ? j : $urandom_range(1, DIM - 1),
                             pick_value());
            end else begin
                add_item(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                         $urandom_range(DIM, 15), VALUE_W'($urandom));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        waited = 0;
        while (nearest_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (nearest_q.size() != 0) begin
            errors += nearest_q.size();
            $display("ERROR: %0d expected results never arrived", nearest_q.size());
        end

        $display("Summary: %0d transactions in (%0d loads, %0d query elements, %0d ignored)",
                 n_accepted, n_loads, n_queries, n_ignored);
        $display("Summary: %0d nearest-codeword results checked, %0d saturated, %0d errors",
                 n_results, n_saturated, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Driver: bursts of transactions with random gaps, valid held until accepted
    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                tokhura_predict(active_item);
                n_accepted++;
                if (active_item.elem >= DIM) n_ignored++;
                else if (active_item.op == OP_LOAD) n_loads++;
                else n_queries++;
            end
            if (!i_valid || o_ready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0 &&
                             (!pending_items[0].drain || nearest_q.size() == 0)) begin
                    active_item = pending_items.pop_front();
                    next_valid  = 1'b1;
                    i_opcode         <= active_item.op;
                    i_codeword_index <= active_item.cw;
                    i_element_index  <= active_item.elem;
                    i_element_value  <= active_item.value;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                i_valid <= next_valid;
            end
        end
    end

    // Receiver: ready pattern switches between free-running, random and rhythmic stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= (cycle_cnt % 8) == 0;
                default: i_ready <= $urandom_range(0, 9) != 0;
            endcase
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_nearest want;
        if (i_rst_n && o_valid && i_ready) begin
            if (nearest_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result index=%0d distance=%0d",
                             o_best_index, o_best_distance);
            end else begin
                want = nearest_q.pop_front();
                n_results++;
                if (want.distance == DIST_MAX) n_saturated++;
                if (o_best_index !== want.idx || o_best_distance !== want.distance) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result %0d index exp=%0d got=%0d %s=%0d got=%0d",
                                 n_results, want.idx, o_best_index, "distance exp",
                                 want.distance, o_best_distance);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

@@ files.f @@
rtl/core/tncs_pkg.sv
rtl/core/tncs_codebook.sv
rtl/core/tncs_term.sv
rtl/core/tncs_accum.sv
rtl/core/tokhura_nearest_codeword_search_top.sv
test/tokhura_nearest_codeword_search_top_test.sv
